### rtl/dxsort_pkg.sv
// Shared constants, payload types, state and command types for the descending exchange sorter.
package dxsort_pkg;

	localparam int MAX_ITEMS = 16;
	localparam int DATA_W    = 32;
	localparam int IDX_W     = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     final_res;
		logic                     truncated;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD_P,
		ST_FETCH_P,
		ST_CMP,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		RD_P,
		RD_P_NEXT,
		RD_Q_NEXT
	} rd_sel_t;

	typedef struct packed {
		logic    load;
		logic    clear_set;
		logic    p_init;
		logic    p_inc;
		logic    q_init;
		logic    q_inc;
		logic    cur_from_ram;
		logic    cmp_step;
		logic    emit;
		rd_sel_t rd_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic p_last;
		logic q_last;
		logic out_free;
	} dp_status_t;

endpackage

### rtl/dxsort_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dxsort_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/dxsort_datapath.sv
// Datapath: element store, set count, sort indexes, running maximum and result register.
module dxsort_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dxsort_pkg::dp_cmd_t  cmd,
	input  dxsort_pkg::item_t    item_data,
	output dxsort_pkg::dp_status_t status,
	output logic                 res_valid,
	output dxsort_pkg::result_t  res_data,
	input  logic                 res_stall
);

	logic [dxsort_pkg::CNT_W-1:0]       count_q;
	logic [dxsort_pkg::CNT_W-1:0]       count_m1;
	logic                               ovf_q;
	logic [dxsort_pkg::IDX_W-1:0]       p_q;
	logic [dxsort_pkg::IDX_W-1:0]       q_q;
	logic [dxsort_pkg::IDX_W-1:0]       last_idx;
	logic signed [dxsort_pkg::DATA_W-1:0] cur_q;
	logic signed [dxsort_pkg::DATA_W-1:0] rdata;
	logic                               res_valid_q;
	dxsort_pkg::result_t                res_q;

	logic                               full;
	logic                               swap;
	logic                               we;
	logic [dxsort_pkg::IDX_W-1:0]       waddr;
	logic [dxsort_pkg::DATA_W-1:0]      wdata;
	logic [dxsort_pkg::IDX_W-1:0]       raddr;

	assign full     = (count_q == dxsort_pkg::CNT_W'(dxsort_pkg::MAX_ITEMS));
	assign count_m1 = count_q - dxsort_pkg::CNT_W'(1);
	assign last_idx = count_m1[dxsort_pkg::IDX_W-1:0];
	assign swap     = (cur_q < rdata);

	// the running value always holds what position p would hold after the swaps so far
	always_comb begin
		we    = 1'b0;
		waddr = q_q;
		wdata = cur_q;
		if (cmd.load) begin
			we    = !full;
			waddr = count_q[dxsort_pkg::IDX_W-1:0];
			wdata = item_data.value;
		end else if (cmd.cmp_step) begin
			we    = swap;
			waddr = q_q;
			wdata = cur_q;
		end
	end

	always_comb begin
		unique case (cmd.rd_sel)
			dxsort_pkg::RD_P:      raddr = p_q;
			dxsort_pkg::RD_P_NEXT: raddr = p_q + dxsort_pkg::IDX_W'(1);
			dxsort_pkg::RD_Q_NEXT: raddr = q_q + dxsort_pkg::IDX_W'(1);
			default:               raddr = p_q;
		endcase
	end

	dxsort_ram #(
		.WIDTH(dxsort_pkg::DATA_W),
		.DEPTH(dxsort_pkg::MAX_ITEMS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_q       <= 1'b0;
			p_q         <= '0;
			q_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_set) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (cmd.load) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + dxsort_pkg::CNT_W'(1);
				end
			end
			if (cmd.p_init) begin
				p_q <= '0;
			end else if (cmd.p_inc) begin
				p_q <= p_q + dxsort_pkg::IDX_W'(1);
			end
			if (cmd.q_init) begin
				q_q <= p_q + dxsort_pkg::IDX_W'(1);
			end else if (cmd.q_inc) begin
				q_q <= q_q + dxsort_pkg::IDX_W'(1);
			end
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cur_from_ram || (cmd.cmp_step && swap)) begin
			cur_q <= rdata;
		end
		if (cmd.emit) begin
			res_q.sorted_value <= cur_q;
			res_q.final_res    <= (p_q == last_idx);
			res_q.truncated    <= ovf_q;
		end
	end

	assign status.p_last   = (p_q == last_idx);
	assign status.q_last   = (q_q == last_idx);
	assign status.out_free = !res_valid_q || !res_stall;

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

### rtl/dxsort_ctrl.sv
// Controller: sequences loading, the exchange passes and result emission.
module dxsort_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  logic                   item_last,
	output logic                   item_stall,
	input  dxsort_pkg::dp_status_t status,
	output dxsort_pkg::dp_cmd_t    cmd
);

	dxsort_pkg::state_t state_q;
	dxsort_pkg::state_t state_nxt;
	logic               accept;

	assign accept = item_valid && (state_q == dxsort_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dxsort_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			dxsort_pkg::ST_IDLE: begin
				if (accept && item_last) begin
					state_nxt = dxsort_pkg::ST_LOAD_P;
				end
			end
			dxsort_pkg::ST_LOAD_P: begin
				state_nxt = dxsort_pkg::ST_FETCH_P;
			end
			dxsort_pkg::ST_FETCH_P: begin
				state_nxt = status.p_last ? dxsort_pkg::ST_EMIT : dxsort_pkg::ST_CMP;
			end
			dxsort_pkg::ST_CMP: begin
				if (status.q_last) begin
					state_nxt = dxsort_pkg::ST_EMIT;
				end
			end
			dxsort_pkg::ST_EMIT: begin
				if (status.out_free) begin
					state_nxt = status.p_last ? dxsort_pkg::ST_IDLE : dxsort_pkg::ST_LOAD_P;
				end
			end
			default: state_nxt = dxsort_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = dxsort_pkg::RD_P;
		item_stall = (state_q != dxsort_pkg::ST_IDLE);
		unique case (state_q)
			dxsort_pkg::ST_IDLE: begin
				cmd.load   = accept;
				cmd.p_init = accept && item_last;
			end
			dxsort_pkg::ST_LOAD_P: begin
				cmd.rd_sel = dxsort_pkg::RD_P;
			end
			dxsort_pkg::ST_FETCH_P: begin
				// take position p and prefetch p+1
				cmd.cur_from_ram = 1'b1;
				cmd.q_init       = 1'b1;
				cmd.rd_sel       = dxsort_pkg::RD_P_NEXT;
			end
			dxsort_pkg::ST_CMP: begin
				cmd.cmp_step = 1'b1;
				cmd.q_inc    = !status.q_last;
				cmd.rd_sel   = dxsort_pkg::RD_Q_NEXT;
			end
			dxsort_pkg::ST_EMIT: begin
				cmd.emit      = status.out_free;
				cmd.p_inc     = status.out_free && !status.p_last;
				cmd.clear_set = status.out_free && status.p_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### rtl/descending_exchange_sort_unit.sv
// Top level: descending exchange sorter, controller plus datapath.
// Loading: one item per cycle, no result; the item marked last starts the sort.
// Sorting n elements: each position p is read, fetched, compared once with every later entry
// through the single store read port, and emitted. One result per pass; a stalled result holds
// the pass in emit, and a new set loads once the final result is registered.
// Asynchronous active-low reset clears count, overflow flag, state and result valid;
// the element store is not cleared and needs no clearing pass.
module descending_exchange_sort_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  dxsort_pkg::item_t   item_data,
	output logic                res_valid,
	input  logic                res_stall,
	output dxsort_pkg::result_t res_data
);

	dxsort_pkg::dp_cmd_t    cmd;
	dxsort_pkg::dp_status_t status;

	dxsort_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_last (item_data.last),
		.item_stall(item_stall),
		.status    (status),
		.cmd       (cmd)
	);

	dxsort_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.item_data(item_data),
		.status   (status),
		.res_valid(res_valid),
		.res_data (res_data),
		.res_stall(res_stall)
	);

endmodule

### rtl/dxsort_checker.sv
// Port-level checker for the descending exchange sorter, bound to the top level.
module dxsort_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_stall,
	input dxsort_pkg::item_t   item_data,
	input logic                res_valid,
	input logic                res_stall,
	input dxsort_pkg::result_t res_data
);

	// hold a stalled result
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("stalled result changed");

	// closing a set stops loading
	a_close_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item_data.last |=> item_stall)
		else $error("input taken right after the closing item");

	// no loading while a run still has results to give
	a_run_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.final_res |-> item_stall)
		else $error("input open in the middle of a run");

endmodule

bind descending_exchange_sort_unit dxsort_checker u_dxsort_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.item_valid(item_valid),
	.item_stall(item_stall),
	.item_data (item_data),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res_data  (res_data)
);

### verif/descending_exchange_sort_unit_tb.sv
// Self-checking testbench for the descending exchange sorter: random sets, idling and back-pressure.
module descending_exchange_sort_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HOLD_CYCLES  = 500;
	localparam int SETTLE       = 60;
	localparam int MAX_GAP      = 30;
	localparam int PHASE_VALUES = 22;

	typedef enum int {
		VAL_FULL,
		VAL_NARROW,
		VAL_EXTREME
	} value_mode_t;

	// Mirrors the sorter: gathers a set, orders it largest first, queues the due results.
	class descending_order_board;
		logic signed [dxsort_pkg::DATA_W-1:0] open_set[dxsort_pkg::MAX_ITEMS];
		int                                   open_cnt;
		bit                                   set_dropped;
		dxsort_pkg::result_t                  sorted_due[$];
		int                                   mismatches;
		int                                   results_checked;
		int                                   values_taken;
		int                                   sets_closed;
		int                                   truncated_sets;

		function new();
			open_cnt        = 0;
			set_dropped     = 1'b0;
			mismatches      = 0;
			results_checked = 0;
			values_taken    = 0;
			sets_closed     = 0;
			truncated_sets  = 0;
		endfunction

		function void take_value(dxsort_pkg::item_t it);
			logic signed [dxsort_pkg::DATA_W-1:0] tmp;
			dxsort_pkg::result_t                  r;
			values_taken++;
			if (open_cnt < dxsort_pkg::MAX_ITEMS) begin
				open_set[open_cnt] = it.value;
				open_cnt++;
			end else begin
				set_dropped = 1'b1;
			end
			if (!it.last)
				return;
			// swap whenever the earlier entry is smaller
			for (int p = 0; p < open_cnt; p++) begin
				for (int q = p + 1; q < open_cnt; q++) begin
					if (open_set[p] < open_set[q]) begin
						tmp         = open_set[p];
						open_set[p] = open_set[q];
						open_set[q] = tmp;
					end
				end
			end
			for (int k = 0; k < open_cnt; k++) begin
				r.sorted_value = open_set[k];
				r.final_res    = (k == open_cnt - 1);
				r.truncated    = set_dropped;
				sorted_due.push_back(r);
			end
			sets_closed++;
			if (set_dropped)
				truncated_sets++;
			open_cnt    = 0;
			set_dropped = 1'b0;
		endfunction

		function void check_sorted(dxsort_pkg::result_t got);
			dxsort_pkg::result_t want;
			if (sorted_due.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected result value=%0d final=%b trunc=%b", $realtime,
						got.sorted_value, got.final_res, got.truncated);
				mismatches++;
				return;
			end
			want = sorted_due.pop_front();
			results_checked++;
			if (got.sorted_value !== want.sorted_value || got.final_res !== want.final_res ||
					got.truncated !== want.truncated) begin
				if (mismatches < 10)
					$display("%0t: result mismatch: expected value=%0d final=%b trunc=%b,",
						$realtime, want.sorted_value, want.final_res, want.truncated,
						" got value=%0d final=%b trunc=%b",
						got.sorted_value, got.final_res, got.truncated);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return sorted_due.size();
		endfunction
	endclass

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                item_valid  = 1'b0;
	logic                item_stall;
	dxsort_pkg::item_t   item_data   = '0;
	logic                res_valid;
	logic                res_stall   = 1'b0;
	dxsort_pkg::result_t res_data;

	descending_order_board board;
	int    send_idle_pct = 0;
	int    stall_pct     = 0;
	logic  hold_toggle   = 1'b0;
	int    values_sent   = 0;

	descending_exchange_sort_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item_data  (item_data),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_data   (res_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("descending_exchange_sort_unit_tb: FAIL");
		$finish;
	end

	// Sample both channels at the edge that completes a transfer.
	always @(posedge clk) begin
		if (arst_n && board != null) begin
			if (item_valid && !item_stall)
				board.take_value(item_data);
			if (res_valid && !res_stall)
				board.check_sorted(res_data);
		end
	end

	// Receiver: random stall, or a long hold-off when the toggle flips.
	initial begin : receiver
		int   hold_left;
		logic seen_toggle;
		hold_left   = 0;
		seen_toggle = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_toggle != seen_toggle) begin
				seen_toggle = hold_toggle;
				hold_left   = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	function automatic logic signed [dxsort_pkg::DATA_W-1:0] pick_value(value_mode_t mode);
		case (mode)
			VAL_FULL:   return $urandom;
			VAL_NARROW: return int'($urandom_range(16)) - 8;
			default: begin
				case ($urandom_range(4))
					0:       return 32'sh8000_0000;
					1:       return 32'sh7fff_ffff;
					2:       return 32'sh0000_0000;
					3:       return -32'sd1;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	// Offer one value; valid stays high on return so the next call can follow without a gap.
	task automatic send_value(input logic signed [dxsort_pkg::DATA_W-1:0] v,
			input logic is_last);
		int                gap;
		dxsort_pkg::item_t it;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		it.value    = v;
		it.last     = is_last;
		item_valid <= 1'b1;
		item_data  <= it;
		do @(posedge clk); while (item_stall);
		values_sent++;
	endtask

	task automatic send_random_set();
		int          n;
		int          pick;
		value_mode_t mode;
		pick = $urandom_range(99);
		if (pick < 10)
			n = $urandom_range(dxsort_pkg::MAX_ITEMS + 4, dxsort_pkg::MAX_ITEMS + 1);
		else if (pick < 25)
			n = dxsort_pkg::MAX_ITEMS;
		else
			n = $urandom_range(dxsort_pkg::MAX_ITEMS, 1);
		mode = value_mode_t'($urandom_range(2));
		for (int k = 0; k < n; k++)
			send_value(pick_value(mode), k == n - 1);
	endtask

	// Stop offering and wait for every due result.
	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin : stimulus
		int send_mix[4];
		int stall_mix[4];
		int phase_end;
		send_mix  = '{0, 72, 0, 38};
		stall_mix = '{0, 0, 72, 38};
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: single value, extremes, equal pair, overflow closed by a dropped value.
		send_value(32'sh7fff_ffff, 1'b1);
		send_value(32'sh8000_0000, 1'b0);
		send_value(32'sh7fff_ffff, 1'b0);
		send_value(32'sh0000_0000, 1'b0);
		send_value(-32'sd1, 1'b1);
		send_value(32'sd7, 1'b0);
		send_value(32'sd7, 1'b1);
		for (int k = 0; k < dxsort_pkg::MAX_ITEMS + 2; k++)
			send_value(pick_value(VAL_EXTREME), k == dxsort_pkg::MAX_ITEMS + 1);
		wait_drained();

		// Hold the result side off while full sets keep coming; input must back up.
		hold_toggle <= ~hold_toggle;
		for (int s = 0; s < 2; s++) begin
			for (int k = 0; k < dxsort_pkg::MAX_ITEMS; k++)
				send_value(pick_value(VAL_FULL), k == dxsort_pkg::MAX_ITEMS - 1);
		end
		wait_drained();

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_mix[ph];
			stall_pct    <= stall_mix[ph];
			phase_end     = values_sent + PHASE_VALUES;
			while (values_sent < phase_end)
				send_random_set();
			wait_drained();
		end

		$display("Sent %0d values in %0d sets (%0d over capacity), checked %0d sorted results",
			board.values_taken, board.sets_closed, board.truncated_sets, board.results_checked);
		$display("across idle, sender-gap, receiver-stall and mixed phases plus a long hold-off");
		if (board.mismatches == 0 && board.outstanding() == 0) begin
			$display("descending_exchange_sort_unit_tb: PASS");
		end else begin
			$display("descending_exchange_sort_unit_tb: FAIL");
		end
		$finish;
	end

endmodule

### sim.f
rtl/dxsort_pkg.sv
rtl/dxsort_ram.sv
rtl/dxsort_datapath.sv
rtl/dxsort_ctrl.sv
rtl/descending_exchange_sort_unit.sv
rtl/dxsort_checker.sv
verif/descending_exchange_sort_unit_tb.sv
